// File: hdl/srd_pkg.sv
// Shared item types and pipeline constants for the refraction direction block.
package srd_pkg;

    typedef struct packed {
        logic        [15:0] source_index;
        logic        [15:0] target_index;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic               total_reflection;
    } t_out_item;

    // index ratio: 20 quotient bits, 4 per stage
    localparam int DIV_PER_STAGE = 4;
    localparam int DIV_STAGES    = 5;
    localparam logic [19:0] R_MAX = 20'hFFFFF;

    // square root of a 64-bit radicand: 32 root bits, 2 per stage
    localparam int SQ_PER_STAGE = 2;
    localparam int SQ_STAGES    = 16;

    // 1.0 in Q.28 and in Q.44
    localparam logic signed [41:0] ONE_Q28 = 42'sd268435456;
    localparam logic signed [63:0] ONE_Q44 = 64'sd17592186044416;
    // rounding offset for the Q.36 to Q.14 step
    localparam logic signed [52:0] HALF_Q22 = 53'sd2097152;

endpackage

// File: hdl/srd_div.sv
// Pipelined restoring divider: floor(source * 2^16 / target), overflow flagged.
module srd_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_src,
    input  logic [15:0] i_tgt,
    output logic [19:0] o_quo,
    output logic        o_ovf
);

    logic [15:0] r_rem [srd_pkg::DIV_STAGES];
    logic [19:0] r_low [srd_pkg::DIV_STAGES];
    logic [19:0] r_quo [srd_pkg::DIV_STAGES];
    logic [15:0] r_den [srd_pkg::DIV_STAGES];
    logic        r_ovf [srd_pkg::DIV_STAGES];

    logic [15:0] n_rem [srd_pkg::DIV_STAGES];
    logic [19:0] n_low [srd_pkg::DIV_STAGES];
    logic [19:0] n_quo [srd_pkg::DIV_STAGES];
    logic [15:0] n_den [srd_pkg::DIV_STAGES];
    logic        n_ovf [srd_pkg::DIV_STAGES];

    always_comb begin
        logic [15:0] v_rem;
        logic [19:0] v_low;
        logic [19:0] v_quo;
        logic [15:0] v_den;
        logic        v_ovf;
        logic [16:0] v_try;
        for (int st = 0; st < srd_pkg::DIV_STAGES; st++) begin
            if (st == 0) begin
                // upper 12 quotient bits are zero unless the ratio overflows
                v_rem = {4'b0, i_src[15:4]};
                v_low = {i_src[3:0], 16'b0};
                v_quo = '0;
                v_den = i_tgt;
                v_ovf = ({4'b0, i_src} >= {i_tgt, 4'b0});
            end else begin
                v_rem = r_rem[st-1];
                v_low = r_low[st-1];
                v_quo = r_quo[st-1];
                v_den = r_den[st-1];
                v_ovf = r_ovf[st-1];
            end
            for (int j = 0; j < srd_pkg::DIV_PER_STAGE; j++) begin
                v_try = {v_rem, v_low[19]};
                v_low = {v_low[18:0], 1'b0};
                if (v_try >= {1'b0, v_den}) begin
                    v_try = v_try - {1'b0, v_den};
                    v_quo = {v_quo[18:0], 1'b1};
                end else begin
                    v_quo = {v_quo[18:0], 1'b0};
                end
                v_rem = v_try[15:0];
            end
            n_rem[st] = v_rem;
            n_low[st] = v_low;
            n_quo[st] = v_quo;
            n_den[st] = v_den;
            n_ovf[st] = v_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_low <= n_low;
            r_quo <= n_quo;
            r_den <= n_den;
            r_ovf <= n_ovf;
        end
    end

    assign o_quo = r_quo[srd_pkg::DIV_STAGES-1];
    assign o_ovf = r_ovf[srd_pkg::DIV_STAGES-1];

endmodule

// File: hdl/srd_sqrt.sv
// Pipelined digit-by-digit integer square root of a 64-bit radicand.
module srd_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    logic [35:0] r_rem  [srd_pkg::SQ_STAGES];
    logic [31:0] r_root [srd_pkg::SQ_STAGES];
    logic [63:0] r_rad  [srd_pkg::SQ_STAGES];

    logic [35:0] n_rem  [srd_pkg::SQ_STAGES];
    logic [31:0] n_root [srd_pkg::SQ_STAGES];
    logic [63:0] n_rad  [srd_pkg::SQ_STAGES];

    always_comb begin
        logic [35:0] v_rem;
        logic [35:0] v_trial;
        logic [31:0] v_root;
        logic [63:0] v_rad;
        for (int st = 0; st < srd_pkg::SQ_STAGES; st++) begin
            if (st == 0) begin
                v_rem  = '0;
                v_root = '0;
                v_rad  = i_rad;
            end else begin
                v_rem  = r_rem[st-1];
                v_root = r_root[st-1];
                v_rad  = r_rad[st-1];
            end
            for (int j = 0; j < srd_pkg::SQ_PER_STAGE; j++) begin
                // remainder stays below 2*root+1, so the top bits are free
                v_rem   = {v_rem[33:0], v_rad[63:62]};
                v_rad   = {v_rad[61:0], 2'b00};
                v_trial = {2'b00, v_root, 2'b01};
                if (v_rem >= v_trial) begin
                    v_rem  = v_rem - v_trial;
                    v_root = {v_root[30:0], 1'b1};
                end else begin
                    v_root = {v_root[30:0], 1'b0};
                end
            end
            n_rem[st]  = v_rem;
            n_root[st] = v_root;
            n_rad[st]  = v_rad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
        end
    end

    assign o_root = r_root[srd_pkg::SQ_STAGES-1];

endmodule

// File: hdl/snell_refraction_direction_top.sv
// Top level: pipelined vector Snell refraction with output queue.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | into      | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  out     | out of    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//
// One item enters per cycle if the queue has room; it passes the pipeline,
// then the output queue. Depth is set by the 5-stage index divider and the
// 16-stage square root unit, with the multiply stages around them.
// Reset (i_rst_n low, synchronous) empties the pipeline and the queue.
// The whole pipeline advances together while the two-entry output queue
// has room; a stalled consumer fills the queue, then holds o_in_ready low.
module snell_refraction_direction_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  srd_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output srd_pkg::t_out_item  o_out_data
);

    localparam int NSTG = 29;

    // side data that rides along the square root stages
    typedef struct packed {
        logic signed [41:0] rc;
        logic signed [36:0] rl_x;
        logic signed [36:0] rl_y;
        logic signed [36:0] rl_z;
        logic signed [15:0] n_x;
        logic signed [15:0] n_y;
        logic signed [15:0] n_z;
        logic               tir;
    } t_sq_side;

    // rounding to Q2.14 with saturation
    function automatic logic signed [15:0] f_round_sat(input logic signed [36:0] rl,
                                                       input logic signed [50:0] nm);
        logic signed [52:0] v;
        logic signed [30:0] q;
        v = (53'(rl) <<< 6) + 53'(nm) + srd_pkg::HALF_Q22;
        q = v[52:22];
        if (q > 31'sd32767) begin
            return 16'sh7FFF;
        end else if (q < -31'sd32768) begin
            return 16'sh8000;
        end else begin
            return q[15:0];
        end
    endfunction

    logic               en;
    logic [NSTG-1:0]    r_vld;

    // stage 0: input capture
    srd_pkg::t_in_item  r_a;
    // stage 1: dot products
    logic signed [31:0] r1_p [3];
    logic signed [15:0] r1_l [3];
    logic signed [15:0] r1_n [3];
    // stage 2: c
    logic signed [20:0] r2_c;
    logic signed [15:0] r2_l [3];
    logic signed [15:0] r2_n [3];
    // stages 3..5: 1 - c^2, waiting for the divider
    logic signed [20:0] r3_c, r4_c, r5_c;
    logic signed [37:0] r3_om, r4_om, r5_om;
    logic signed [15:0] r3_l [3];
    logic signed [15:0] r4_l [3];
    logic signed [15:0] r5_l [3];
    logic signed [15:0] r3_n [3];
    logic signed [15:0] r4_n [3];
    logic signed [15:0] r5_n [3];
    // stage 6: ratio r
    logic        [19:0] r6_r;
    logic signed [20:0] r6_c;
    logic signed [37:0] r6_om;
    logic signed [15:0] r6_l [3];
    logic signed [15:0] r6_n [3];
    // stage 7: r^2, r*c, r*l
    logic        [23:0] r7_r2;
    logic signed [41:0] r7_rc;
    logic signed [36:0] r7_rl [3];
    logic signed [37:0] r7_om;
    logic signed [15:0] r7_n [3];
    // stage 8: partial products of r2 * (1 - c^2)
    logic        [42:0] r8_pplo;
    logic signed [43:0] r8_pphi;
    logic signed [41:0] r8_rc;
    logic signed [36:0] r8_rl [3];
    logic signed [15:0] r8_n [3];
    // stage 9: k
    logic signed [63:0] r9_k;
    t_sq_side           r9_side;
    // stages 10..25: square root and its side line
    t_sq_side           r_sq [srd_pkg::SQ_STAGES];
    // stage 26: m
    logic signed [34:0] r26_m;
    logic signed [36:0] r26_rl [3];
    logic signed [15:0] r26_n [3];
    logic               r26_tir;
    // stage 27: n*m
    logic signed [50:0] r27_nm [3];
    logic signed [36:0] r27_rl [3];
    logic               r27_tir;
    // stage 28: result
    srd_pkg::t_out_item r28_out;

    // output queue
    logic [1:0]         r_cnt;
    srd_pkg::t_out_item r_q0, r_q1;

    logic [19:0]        w_quo;
    logic               w_ovf;
    logic [31:0]        w_root;
    logic signed [33:0] w_dot;
    logic signed [34:0] w_neg;
    logic signed [41:0] w_cc;
    logic signed [41:0] w_om;
    logic        [39:0] w_rr;
    logic signed [63:0] w_rom;
    logic signed [63:0] w_k;
    logic signed [34:0] w_m;
    logic               push, pop;

    assign en         = (r_cnt != 2'd2);
    assign o_in_ready = en;

    srd_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_src (r_a.source_index),
        .i_tgt (r_a.target_index),
        .o_quo (w_quo),
        .o_ovf (w_ovf)
    );

    srd_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r9_k),
        .o_root (w_root)
    );

    assign w_dot = r1_p[0] + r1_p[1] + r1_p[2];
    assign w_neg = -w_dot;
    assign w_cc  = r2_c * r2_c;
    assign w_om  = srd_pkg::ONE_Q28 - w_cc;
    assign w_rr  = r6_r * r6_r;
    assign w_rom = (64'(r8_pphi) <<< 19) + $signed({21'b0, r8_pplo});
    assign w_k   = srd_pkg::ONE_Q44 - w_rom;
    assign w_m   = $signed(r_sq[srd_pkg::SQ_STAGES-1].rc[41:8]) - $signed({3'b0, w_root});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= i_in_data;

            r1_p[0] <= r_a.normal_x * r_a.dir_x;
            r1_p[1] <= r_a.normal_y * r_a.dir_y;
            r1_p[2] <= r_a.normal_z * r_a.dir_z;
            r1_l    <= '{r_a.dir_x, r_a.dir_y, r_a.dir_z};
            r1_n    <= '{r_a.normal_x, r_a.normal_y, r_a.normal_z};

            // c = floor(-dot / 2^14)
            r2_c <= w_neg[34:14];
            r2_l <= r1_l;
            r2_n <= r1_n;

            r3_c  <= r2_c;
            r3_om <= w_om[37:0];
            r3_l  <= r2_l;
            r3_n  <= r2_n;
            r4_c  <= r3_c;
            r4_om <= r3_om;
            r4_l  <= r3_l;
            r4_n  <= r3_n;
            r5_c  <= r4_c;
            r5_om <= r4_om;
            r5_l  <= r4_l;
            r5_n  <= r4_n;

            r6_r  <= w_ovf ? srd_pkg::R_MAX : w_quo;
            r6_c  <= r5_c;
            r6_om <= r5_om;
            r6_l  <= r5_l;
            r6_n  <= r5_n;

            r7_r2 <= w_rr[39:16];
            r7_rc <= $signed({1'b0, r6_r}) * r6_c;
            for (int i = 0; i < 3; i++) begin
                r7_rl[i] <= $signed({1'b0, r6_r}) * r6_l[i];
            end
            r7_om <= r6_om;
            r7_n  <= r6_n;

            r8_pplo <= r7_r2 * r7_om[18:0];
            r8_pphi <= $signed({1'b0, r7_r2}) * $signed(r7_om[37:19]);
            r8_rc   <= r7_rc;
            r8_rl   <= r7_rl;
            r8_n    <= r7_n;

            r9_k         <= w_k;
            r9_side.rc   <= r8_rc;
            r9_side.rl_x <= r8_rl[0];
            r9_side.rl_y <= r8_rl[1];
            r9_side.rl_z <= r8_rl[2];
            r9_side.n_x  <= r8_n[0];
            r9_side.n_y  <= r8_n[1];
            r9_side.n_z  <= r8_n[2];
            r9_side.tir  <= w_k[63];

            r_sq[0] <= r9_side;
            for (int i = 1; i < srd_pkg::SQ_STAGES; i++) begin
                r_sq[i] <= r_sq[i-1];
            end

            r26_m   <= w_m;
            r26_rl  <= '{r_sq[srd_pkg::SQ_STAGES-1].rl_x, r_sq[srd_pkg::SQ_STAGES-1].rl_y,
                         r_sq[srd_pkg::SQ_STAGES-1].rl_z};
            r26_n   <= '{r_sq[srd_pkg::SQ_STAGES-1].n_x, r_sq[srd_pkg::SQ_STAGES-1].n_y,
                         r_sq[srd_pkg::SQ_STAGES-1].n_z};
            r26_tir <= r_sq[srd_pkg::SQ_STAGES-1].tir;

            for (int i = 0; i < 3; i++) begin
                r27_nm[i] <= r26_n[i] * r26_m;
            end
            r27_rl  <= r26_rl;
            r27_tir <= r26_tir;

            // total reflection forces a zero vector
            r28_out.out_x <= r27_tir ? '0 : f_round_sat(r27_rl[0], r27_nm[0]);
            r28_out.out_y <= r27_tir ? '0 : f_round_sat(r27_rl[1], r27_nm[1]);
            r28_out.out_z <= r27_tir ? '0 : f_round_sat(r27_rl[2], r27_nm[2]);
            r28_out.total_reflection <= r27_tir;
        end
    end

    // two-entry output queue, head drives the port
    assign push = en && r_vld[NSTG-1];
    assign pop  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop))) begin
            r_q0 <= r28_out;
        end else if (pop && r_cnt == 2'd2) begin
            r_q0 <= r_q1;
        end
        if (push && r_cnt == 2'd1 && !pop) begin
            r_q1 <= r28_out;
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q0;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench for the pipelined Snell refraction block: table, random stimulus, predictor.
module tb;

    localparam int LATENCY    = 40;    // pipe plus queue, with margin
    localparam int STALL_MAX  = 4000;  // cycles with no item moving on either side
    localparam int HOLD_LONG  = 300;   // long receiver hold-off

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    srd_pkg::t_in_item  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    srd_pkg::t_out_item o_out_data;

    snell_refraction_direction_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    typedef struct {
        srd_pkg::t_in_item  ray;
        srd_pkg::t_out_item dir;    // typed-in refracted direction
        bit                 typed;  // dir is valid; else use the predictor
    } t_ray_row;

    srd_pkg::t_out_item refr_q[$];    // refracted directions still owed by the block
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        hold_reqs = 0;     // bumped by the stimulus to ask for a hold-off
    int        hold_seen = 0;
    int        hold_left = 0;
    int        errors = 0;
    int        quiet_cycles = 0;

    // Snell refraction in the block's fixed-point formats.
    function automatic srd_pkg::t_out_item refract(srd_pkg::t_in_item a);
        longint             ratio, dot, c, one_minus, r2, k, root, m, v;
        longint             l[3], n[3];
        longint unsigned    x, res, b;
        srd_pkg::t_out_item o;
        l[0] = longint'(a.dir_x);    l[1] = longint'(a.dir_y);
        l[2] = longint'(a.dir_z);
        n[0] = longint'(a.normal_x); n[1] = longint'(a.normal_y);
        n[2] = longint'(a.normal_z);
        // zero target index saturates like a huge ratio
        if (a.target_index == 16'd0) begin
            ratio = longint'(srd_pkg::R_MAX);
        end else begin
            ratio = (longint'(a.source_index) << 16) / longint'(a.target_index);
            if (ratio > longint'(srd_pkg::R_MAX)) ratio = longint'(srd_pkg::R_MAX);
        end
        dot = n[0] * l[0] + n[1] * l[1] + n[2] * l[2];
        c = (-dot) >>> 14;
        one_minus = (longint'(1) << 28) - c * c;
        r2 = (ratio * ratio) >>> 16;
        k = (longint'(1) << 44) - r2 * one_minus;
        o = '0;
        if (k < 0) begin
            o.total_reflection = 1'b1;
            return o;
        end
        // integer square root, bit-pair method
        x = unsigned'(k);
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        root = signed'(res);
        m = ((ratio * c) >>> 8) - root;
        for (int i = 0; i < 3; i++) begin
            v = (ratio * l[i] * 64 + n[i] * m + (longint'(1) << 21)) >>> 22;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            l[i] = v;
        end
        o.out_x = 16'(l[0]);
        o.out_y = 16'(l[1]);
        o.out_z = 16'(l[2]);
        return o;
    endfunction

    function automatic srd_pkg::t_in_item mk_ray(int src, int tgt, int lx, int ly, int lz,
                                                 int nx, int ny, int nz);
        srd_pkg::t_in_item a;
        a.source_index = 16'(src); a.target_index = 16'(tgt);
        a.dir_x = 16'(lx); a.dir_y = 16'(ly); a.dir_z = 16'(lz);
        a.normal_x = 16'(nx); a.normal_y = 16'(ny); a.normal_z = 16'(nz);
        return a;
    endfunction

    // Random ray: mostly unit-ish vectors and sane indices, some raw noise.
    function automatic srd_pkg::t_in_item rand_ray();
        srd_pkg::t_in_item a;
        int                sel;
        sel = $urandom_range(9);
        if (sel < 3) begin
            a = {$urandom, $urandom, $urandom, $urandom};
        end else begin
            a.source_index = 16'($urandom_range(4096, 12288));
            a.target_index = 16'($urandom_range(4096, 12288));
            if (sel == 3) begin
                // axis-aligned normal, oblique ray
                a.normal_x = 16'sd0; a.normal_y = 16'sd0;
                a.normal_z = ($urandom_range(1) != 0) ? 16'sd16384 : -16'sd16384;
            end else begin
                a.normal_x = 16'($signed($urandom_range(0, 18918)) - 9459);
                a.normal_y = 16'($signed($urandom_range(0, 18918)) - 9459);
                a.normal_z = 16'($signed($urandom_range(0, 18918)) - 9459);
            end
            a.dir_x = 16'($signed($urandom_range(0, 18918)) - 9459);
            a.dir_y = 16'($signed($urandom_range(0, 18918)) - 9459);
            a.dir_z = 16'($signed($urandom_range(0, 18918)) - 9459);
            if (sel == 9) a.source_index = 16'($urandom);  // wide ratio
        end
        return a;
    endfunction

    // Offer one ray; returns once the block has accepted it.
    task automatic send_ray(srd_pkg::t_in_item a, srd_pkg::t_out_item want, bit typed);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= a;
        do @(posedge i_clk); while (!o_in_ready);
        refr_q.push_back(typed ? want : refract(a));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        wait (refr_q.size() == 0);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // Receiver: random ready, or a counted hold-off when asked.
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_LONG - 1;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Output check against the oldest owed direction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (refr_q.size() == 0) begin
                $display("%0t: unexpected item, actual %p", $time, o_out_data);
                errors++;
            end else begin
                srd_pkg::t_out_item w;
                w = refr_q.pop_front();
                if (o_out_data.out_x !== w.out_x) begin
                    $display("%0t: out_x expected %0d actual %0d", $time, w.out_x,
                             o_out_data.out_x);
                    errors++;
                end
                if (o_out_data.out_y !== w.out_y) begin
                    $display("%0t: out_y expected %0d actual %0d", $time, w.out_y,
                             o_out_data.out_y);
                    errors++;
                end
                if (o_out_data.out_z !== w.out_z) begin
                    $display("%0t: out_z expected %0d actual %0d", $time, w.out_z,
                             o_out_data.out_z);
                    errors++;
                end
                if (o_out_data.total_reflection !== w.total_reflection) begin
                    $display("%0t: total_reflection expected %0b actual %0b", $time,
                             w.total_reflection, o_out_data.total_reflection);
                    errors++;
                end
            end
        end
    end

    // Watchdog: no item moved on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_ray_row           rows[$];
        t_ray_row           row;
        srd_pkg::t_out_item zero_dir;
        srd_pkg::t_out_item tir_dir;
        zero_dir = '0;
        tir_dir = '0;
        tir_dir.total_reflection = 1'b1;

        // Directed rows; typed ones follow from the formulas by hand.
        // zero target index: ratio saturates, zero vectors -> reflection
        rows.push_back('{mk_ray(4096, 0, 0, 0, 0, 0, 0, 0), tir_dir, 1'b1});
        // both indices zero
        rows.push_back('{mk_ray(0, 0, 0, 0, 0, 0, 0, 0), tir_dir, 1'b1});
        // equal indices, zero vectors: k is exactly zero
        rows.push_back('{mk_ray(4096, 4096, 0, 0, 0, 0, 0, 0), zero_dir, 1'b1});
        // equal indices, no normal: ray passes straight through
        row.ray = mk_ray(4096, 4096, 16384, 0, 0, 0, 0, 0);
        row.dir = '{16'sd16384, 16'sd0, 16'sd0, 1'b0};
        row.typed = 1'b1;
        rows.push_back(row);
        // largest ratio at grazing incidence
        rows.push_back('{mk_ray(65535, 4096, 0, 16384, 0, 16384, 0, 0), tir_dir, 1'b1});
        // zero source index
        rows.push_back('{mk_ray(0, 65535, 16384, 0, 0, 0, 0, -16384), zero_dir, 1'b0});
        // normal incidence, into and out of denser medium
        rows.push_back('{mk_ray(4096, 6144, 0, 0, -16384, 0, 0, 16384), zero_dir, 1'b0});
        rows.push_back('{mk_ray(6144, 4096, 0, 0, -16384, 0, 0, 16384), zero_dir, 1'b0});
        // ray along the normal (c negative)
        rows.push_back('{mk_ray(6144, 4096, 0, 0, 16384, 0, 0, 16384), zero_dir, 1'b0});
        // oblique 45 degrees, glass to air near the critical angle, then air to glass
        rows.push_back('{mk_ray(6144, 4096, 11585, 0, -11585, 0, 0, 16384), zero_dir,
                         1'b0});
        rows.push_back('{mk_ray(4096, 6144, 11585, 0, -11585, 0, 0, 16384), zero_dir,
                         1'b0});
        // field extremes: non-unit vectors, output saturation
        rows.push_back('{mk_ray(65535, 65535, 32767, 32767, 32767, 32767, 32767, 32767),
                         zero_dir, 1'b0});
        rows.push_back('{mk_ray(65535, 65535, -32768, -32768, -32768, -32768, -32768,
                                -32768), zero_dir, 1'b0});
        rows.push_back('{mk_ray(65535, 4096, -32768, 32767, -32768, 32767, -32768, 32767),
                         zero_dir, 1'b0});
        rows.push_back('{mk_ray(4096, 65535, 32767, -32768, 32767, 32767, -32768, 32767),
                         zero_dir, 1'b0});
        rows.push_back('{mk_ray(12345, 4567, -9459, 9459, -9459, 9459, 9459, 9459),
                         zero_dir, 1'b0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_ray(rows[i].ray, rows[i].dir, rows[i].typed);
        drain();

        // sender idles with chance 36 percent before each offer, receiver not ready 56 percent
        tx_idle_pct = 36;
        rx_idle_pct = 56;
        repeat (150) send_ray(rand_ray(), zero_dir, 1'b0);
        // sender pauses until every owed direction has come out
        drain();

        tx_idle_pct = 56;
        rx_idle_pct = 36;
        repeat (150) send_ray(rand_ray(), zero_dir, 1'b0);

        // long receiver hold-off while rays keep coming: pipeline and queue
        // fill, then input ready must drop
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_reqs++;
        repeat (150) send_ray(rand_ray(), zero_dir, 1'b0);
        drain();

        if (errors == 0 && refr_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// File: sim.f
hdl/srd_pkg.sv
hdl/srd_div.sv
hdl/srd_sqrt.sv
hdl/snell_refraction_direction_top.sv
test/tb.sv
